>>> rtl/teg_pkg.sv
// Shared definitions for the text encoding guesser.
// Guess and confidence codes, byte class constants, the snapshot control struct.
// No dependencies.
`timescale 1ns / 1ps

package teg_pkg;

  localparam int COUNT_BITS_DEF = 24;

  typedef enum logic [2:0] {
    GUESS_NONE     = 3'd0,
    GUESS_UTF16LE  = 3'd1,
    GUESS_UTF16BE  = 3'd2,
    GUESS_UTF8     = 3'd3,
    GUESS_WIN1252  = 3'd4,
    GUESS_LATIN1   = 3'd5
  } guess_e;

  typedef enum logic [1:0] {
    CONF_UNSURE    = 2'd0,
    CONF_PLAUSIBLE = 2'd1,
    CONF_SURE      = 2'd2
  } conf_e;

  localparam logic [7:0] C1_LO     = 8'h80;
  localparam logic [7:0] C1_HI     = 8'h9F;
  localparam logic [7:0] LEAD_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Fewest zero bytes that can make a UTF-16 guess.
  localparam int MIN_ZEROS = 2;

  typedef struct packed {
    logic valid;
    logic empty;
    logic c1_seen;
  } snap_ctrl_t;

endpackage

>>> rtl/teg_stats.sv
// Per-stream byte statistics: previous byte, byte count, saturating counters.
// Captures a snapshot of the final counts at stream end. Depends on teg_pkg.
`timescale 1ns / 1ps

module teg_stats #(
  parameter int COUNT_BITS = teg_pkg::COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              byte_value_i,
  input  logic                    last_byte_i,
  input  logic                    empty_stream_i,
  input  logic                    snap_take_i,
  output teg_pkg::snap_ctrl_t     snap_ctrl_o,
  output logic [COUNT_BITS-1:0]   snap_size_o,
  output logic [COUNT_BITS-1:0]   snap_good_o,
  output logic [COUNT_BITS-1:0]   snap_bad_o,
  output logic [COUNT_BITS-1:0]   snap_zle_o,
  output logic [COUNT_BITS-1:0]   snap_zbe_o
);
  import teg_pkg::*;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                    input logic en);
    logic [COUNT_BITS-1:0] r;
    r = v;
    if (en && (v != {COUNT_BITS{1'b1}})) r = v + COUNT_BITS'(1);
    return r;
  endfunction

  logic                  seen_q;
  logic [7:0]            prev_q;
  logic [COUNT_BITS-1:0] count_q, good_q, bad_q, c1_q, zle_q, zbe_q;
  logic [COUNT_BITS-1:0] count_d, good_d, bad_d, c1_d, zle_d, zbe_d;

  logic cur_cont, prev_lead, prev_ascii, zero_hit, stream_end;
  logic c1_inc, good_inc, bad_inc;

  snap_ctrl_t            snap_ctrl_q;
  logic [COUNT_BITS-1:0] snap_size_q, snap_good_q, snap_bad_q, snap_zle_q, snap_zbe_q;

  always_comb begin
    cur_cont   = (byte_value_i & LEAD_MASK) == CONT_TAG;
    prev_lead  = (prev_q & LEAD_MASK) == LEAD_MASK;
    prev_ascii = !prev_q[7];
    c1_inc     = (byte_value_i >= C1_LO) && (byte_value_i <= C1_HI);
    good_inc   = seen_q && cur_cont && prev_lead;
    bad_inc    = seen_q && ((cur_cont && prev_ascii) || (!cur_cont && prev_lead));
    zero_hit   = seen_q && !cur_cont && (prev_q == 8'h00);
    count_d    = sat_inc(count_q, 1'b1);
    good_d     = sat_inc(good_q, good_inc);
    bad_d      = sat_inc(bad_q, bad_inc);
    c1_d       = sat_inc(c1_q, c1_inc);
    // Position parity is the count of bytes before the current one.
    zbe_d      = sat_inc(zbe_q, zero_hit && count_q[0]);
    zle_d      = sat_inc(zle_q, zero_hit && !count_q[0]);
    stream_end = last_byte_i || empty_stream_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      prev_q  <= 8'h00;
      count_q <= '0;
      good_q  <= '0;
      bad_q   <= '0;
      c1_q    <= '0;
      zle_q   <= '0;
      zbe_q   <= '0;
    end else if (accept_i) begin
      if (stream_end) begin
        seen_q  <= 1'b0;
        prev_q  <= 8'h00;
        count_q <= '0;
        good_q  <= '0;
        bad_q   <= '0;
        c1_q    <= '0;
        zle_q   <= '0;
        zbe_q   <= '0;
      end else begin
        seen_q  <= 1'b1;
        prev_q  <= byte_value_i;
        count_q <= count_d;
        good_q  <= good_d;
        bad_q   <= bad_d;
        c1_q    <= c1_d;
        zle_q   <= zle_d;
        zbe_q   <= zbe_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_ctrl_q <= '0;
    end else if (accept_i && stream_end) begin
      snap_ctrl_q.valid   <= 1'b1;
      snap_ctrl_q.empty   <= empty_stream_i;
      snap_ctrl_q.c1_seen <= c1_d != '0;
    end else if (snap_take_i) begin
      snap_ctrl_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && stream_end) begin
      snap_size_q <= count_d;
      snap_good_q <= good_d;
      snap_bad_q  <= bad_d;
      snap_zle_q  <= zle_d;
      snap_zbe_q  <= zbe_d;
    end
  end

  assign snap_ctrl_o = snap_ctrl_q;
  assign snap_size_o = snap_size_q;
  assign snap_good_o = snap_good_q;
  assign snap_bad_o  = snap_bad_q;
  assign snap_zle_o  = snap_zle_q;
  assign snap_zbe_o  = snap_zbe_q;

endmodule

>>> rtl/teg_decide.sv
// Final decision over a stream snapshot, held in the result register.
// Ratio tests use constant shift-add products instead of division. Depends on teg_pkg.
`timescale 1ns / 1ps

module teg_decide #(
  parameter int COUNT_BITS = teg_pkg::COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  teg_pkg::snap_ctrl_t     snap_ctrl_i,
  input  logic [COUNT_BITS-1:0]   snap_size_i,
  input  logic [COUNT_BITS-1:0]   snap_good_i,
  input  logic [COUNT_BITS-1:0]   snap_bad_i,
  input  logic [COUNT_BITS-1:0]   snap_zle_i,
  input  logic [COUNT_BITS-1:0]   snap_zbe_i,
  output logic                    snap_take_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              guess_code_o,
  output logic [1:0]              confidence_o
);
  import teg_pkg::*;

  localparam int PW = COUNT_BITS + 10;  // room for a count times 1000
  localparam int GW = COUNT_BITS + 4;   // room for a count times 10

  logic [PW-1:0] size_x, le_x, be_x;
  logic [PW-1:0] le_1000, be_1000, le_100p, be_100p;
  logic [GW-1:0] good_x, bad_10;
  logic          le_gt_be, le_le_milli, be_le_milli, le_ge_centi, be_ge_centi;
  guess_e        guess_d, guess_q;
  conf_e         conf_d, conf_q;
  logic          out_valid_q;

  always_comb begin
    size_x  = PW'(snap_size_i);
    le_x    = PW'(snap_zle_i);
    be_x    = PW'(snap_zbe_i);
    le_1000 = (le_x << 10) - (le_x << 4) - (le_x << 3);
    be_1000 = (be_x << 10) - (be_x << 4) - (be_x << 3);
    // z >= floor(s/100) is the same as 100*z + 99 >= s
    le_100p = (le_x << 6) + (le_x << 5) + (le_x << 2) + PW'(99);
    be_100p = (be_x << 6) + (be_x << 5) + (be_x << 2) + PW'(99);
    good_x  = GW'(snap_good_i);
    bad_10  = (GW'(snap_bad_i) << 3) + (GW'(snap_bad_i) << 1);

    le_gt_be    = snap_zle_i > snap_zbe_i;
    le_le_milli = le_1000 <= size_x;
    be_le_milli = be_1000 <= size_x;
    le_ge_centi = le_100p >= size_x;
    be_ge_centi = be_100p >= size_x;

    priority if (snap_ctrl_i.empty) begin
      guess_d = GUESS_NONE;
      conf_d  = CONF_UNSURE;
    end else if (le_gt_be && be_le_milli && le_ge_centi &&
                 (snap_zle_i >= COUNT_BITS'(MIN_ZEROS))) begin
      guess_d = GUESS_UTF16LE;
      conf_d  = CONF_SURE;
    end else if (!le_gt_be && le_le_milli && be_ge_centi &&
                 (snap_zbe_i >= COUNT_BITS'(MIN_ZEROS))) begin
      guess_d = GUESS_UTF16BE;
      conf_d  = CONF_SURE;
    end else if (good_x > bad_10) begin
      guess_d = GUESS_UTF8;
      conf_d  = CONF_SURE;
    end else begin
      guess_d = snap_ctrl_i.c1_seen ? GUESS_WIN1252 : GUESS_LATIN1;
      conf_d  = (snap_bad_i == '0) ? CONF_UNSURE : CONF_PLAUSIBLE;
    end
  end

  // Advance the snapshot when the result register is free or being drained.
  assign snap_take_o = snap_ctrl_i.valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o) begin
      guess_q <= guess_d;
      conf_q  <= conf_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign guess_code_o = guess_q;
  assign confidence_o = conf_q;

endmodule

>>> rtl/text_encoding_guesser.sv
// Text encoding guesser: one byte per beat, one guess per stream.
// Throughput: one byte per cycle unless a waiting snapshot holds the input;
// the counter update is a single saturating increment. The beat with last_byte or
// empty_stream registers the counts in the snapshot; the decision over it is then
// registered in the result register. Reset clears all counters and both pipeline
// valids at once; no clearing pass. Depends on teg_pkg, teg_stats, teg_decide.
`timescale 1ns / 1ps

module text_encoding_guesser #(
  parameter int COUNT_BITS = teg_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  input  logic       empty_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] guess_code_o,
  output logic [1:0] confidence_o
);
  import teg_pkg::*;

  snap_ctrl_t            snap_ctrl;
  logic [COUNT_BITS-1:0] snap_size, snap_good, snap_bad, snap_zle, snap_zbe;
  logic                  snap_take, in_fire;

  // Hold input only while a finished snapshot cannot move on.
  assign in_ready_o = !snap_ctrl.valid || snap_take;
  assign in_fire    = in_valid_i && in_ready_o;

  teg_stats #(.COUNT_BITS(COUNT_BITS)) u_stats (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_fire),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .empty_stream_i (empty_stream_i),
    .snap_take_i    (snap_take),
    .snap_ctrl_o    (snap_ctrl),
    .snap_size_o    (snap_size),
    .snap_good_o    (snap_good),
    .snap_bad_o     (snap_bad),
    .snap_zle_o     (snap_zle),
    .snap_zbe_o     (snap_zbe)
  );

  teg_decide #(.COUNT_BITS(COUNT_BITS)) u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_ctrl_i  (snap_ctrl),
    .snap_size_i  (snap_size),
    .snap_good_i  (snap_good),
    .snap_bad_i   (snap_bad),
    .snap_zle_i   (snap_zle),
    .snap_zbe_i   (snap_zbe),
    .snap_take_o  (snap_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .guess_code_o (guess_code_o),
    .confidence_o (confidence_o)
  );

  a_end_snaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (last_byte_i || empty_stream_i) |=> snap_ctrl.valid)
    else $error("stream end beat did not produce a snapshot");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the result side could drain");

  a_none_unsure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (guess_code_o == GUESS_NONE) |-> confidence_o == CONF_UNSURE)
    else $error("empty stream guess with nonzero confidence");

  a_unicode_sure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((guess_code_o == GUESS_UTF16LE) || (guess_code_o == GUESS_UTF16BE) ||
                    (guess_code_o == GUESS_UTF8)) |-> confidence_o == CONF_SURE)
    else $error("unicode guess without full confidence");

endmodule
